[design/sn2d_pkg.sv]
package sn2d_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW = $clog2(TABLE_DEPTH);
  localparam int TABLE_DW = 8;
  localparam int OFS_W = 25;
  localparam int DOT_W = 26;
  localparam int TERM_W = 47;
  localparam int SUM_W = 49;
  localparam int NOISE_W = 16;
  localparam int GRAD_W = 3;

  localparam logic [29:0] F2_Q30 = 30'd393016785;
  localparam logic [29:0] G2_Q32 = 30'd907633386;
  localparam logic [23:0] G2_Q24 = 24'd3545443;

  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                             cmd;
    logic [TABLE_AW-1:0]              idx;
    logic [TABLE_DW-1:0]              val;
    logic [2:0][TABLE_AW-1:0]         addr;
    logic [2:0][OFS_W-1:0]            ox;
    logic [2:0][OFS_W-1:0]            oy;
    logic [2:0]                       far;
  } hash_item_t;

endpackage

[design/sn2d_perm_ram.sv]
module sn2d_perm_ram (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [sn2d_pkg::TABLE_AW-1:0]     wr_addr,
  input  logic [sn2d_pkg::TABLE_DW-1:0]     wr_data,
  input  logic                              rd_en,
  input  logic [sn2d_pkg::TABLE_AW-1:0]     rd_addr,
  output logic [sn2d_pkg::TABLE_DW-1:0]     rd_data
);

  logic [sn2d_pkg::TABLE_DW-1:0] mem [sn2d_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/sn2d_front.sv]
module sn2d_front #(
  parameter int COORD_FRAC_BITS = sn2d_pkg::COORD_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic signed [sn2d_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [sn2d_pkg::COORD_W-1:0]   y_coord,
  input  logic [sn2d_pkg::TABLE_AW-1:0]         table_index,
  input  logic [sn2d_pkg::TABLE_DW-1:0]         table_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sn2d_pkg::hash_item_t                  item
);

  localparam int FB = COORD_FRAC_BITS;
  localparam int AW = sn2d_pkg::TABLE_AW;
  localparam int DW = sn2d_pkg::TABLE_DW;
  localparam int OW = sn2d_pkg::OFS_W;
  localparam int SXY_W = sn2d_pkg::COORD_W + 1;
  localparam int PROD_W = SXY_W + 30;
  localparam int XS_W = SXY_W + 1;
  localparam int I_W = XS_W - FB;
  localparam int D_W = XS_W + 1;
  localparam int IJ_W = I_W + 1;
  localparam int TP_W = IJ_W + 31;
  localparam int X0_W = 60 - FB;
  localparam int UP = 24 - FB;
  localparam int XW = X0_W + 2;
  localparam logic signed [30:0] F2S = {1'b0, sn2d_pkg::F2_Q30};
  localparam logic signed [30:0] G2S = {1'b0, sn2d_pkg::G2_Q32};
  localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< 24;
  localparam logic signed [XW-1:0] G2_X = XW'(sn2d_pkg::G2_Q24);

  logic [6:1] v;
  logic [6:1] en;

  logic                     f1_cmd, f2_cmd, f3_cmd, f4_cmd, f5_cmd;
  logic [AW-1:0]            f1_idx, f2_idx, f3_idx, f4_idx, f5_idx;
  logic [DW-1:0]            f1_val, f2_val, f3_val, f4_val, f5_val;
  logic signed [sn2d_pkg::COORD_W-1:0] f1_x, f1_y, f2_x, f2_y;
  logic signed [SXY_W-1:0]  f1_sum;
  logic signed [PROD_W-1:0] f2_prod;
  logic signed [I_W-1:0]    f3_i, f3_j;
  logic signed [D_W-1:0]    f3_dx, f3_dy, f4_dx, f4_dy;
  logic signed [TP_W-1:0]   f4_tp;
  logic [AW-1:0]            f4_ii, f5_ii;
  logic signed [X0_W-1:0]   f5_x0, f5_y0;
  logic [DW-1:0]            pa, pb, f5_pa, f5_pb;

  logic signed [SXY_W-1:0]  s;
  logic signed [XS_W-1:0]   xsum, ysum;
  logic signed [IJ_W-1:0]   ij;
  logic signed [TP_W-8-1:0] t;
  logic                     gt;
  logic signed [XW-1:0]     ofs_x [3];
  logic signed [XW-1:0]     ofs_y [3];
  logic                     load3;

  always_comb begin
    en[6] = !v[6] || out_ready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[1];
  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f1_cmd <= cmd;
      f1_idx <= table_index;
      f1_val <= table_value;
      f1_x <= x_coord;
      f1_y <= y_coord;
      f1_sum <= SXY_W'(x_coord) + SXY_W'(y_coord);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      f2_cmd <= f1_cmd;
      f2_idx <= f1_idx;
      f2_val <= f1_val;
      f2_x <= f1_x;
      f2_y <= f1_y;
      f2_prod <= PROD_W'(f1_sum) * PROD_W'(F2S);
    end
  end

  assign s = $signed(f2_prod[PROD_W-1:30]);
  assign xsum = XS_W'(f2_x) + XS_W'(s);
  assign ysum = XS_W'(f2_y) + XS_W'(s);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      f3_cmd <= f2_cmd;
      f3_idx <= f2_idx;
      f3_val <= f2_val;
      f3_i <= xsum[XS_W-1:FB];
      f3_j <= ysum[XS_W-1:FB];
      f3_dx <= D_W'($signed({1'b0, xsum[FB-1:0]})) - D_W'(s);
      f3_dy <= D_W'($signed({1'b0, ysum[FB-1:0]})) - D_W'(s);
    end
  end

  assign load3 = en[4] && v[3] && (f3_cmd == sn2d_pkg::CMD_LOAD);

  sn2d_perm_ram u_ram_j0 (
    .clk     (clk),
    .wr_en   (load3),
    .wr_addr (f3_idx),
    .wr_data (f3_val),
    .rd_en   (en[4]),
    .rd_addr (f3_j[AW-1:0]),
    .rd_data (pa)
  );

  sn2d_perm_ram u_ram_j1 (
    .clk     (clk),
    .wr_en   (load3),
    .wr_addr (f3_idx),
    .wr_data (f3_val),
    .rd_en   (en[4]),
    .rd_addr (f3_j[AW-1:0] + AW'(1)),
    .rd_data (pb)
  );

  assign ij = IJ_W'(f3_i) + IJ_W'(f3_j);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      f4_cmd <= f3_cmd;
      f4_idx <= f3_idx;
      f4_val <= f3_val;
      f4_dx <= f3_dx;
      f4_dy <= f3_dy;
      f4_ii <= f3_i[AW-1:0];
      f4_tp <= TP_W'(ij) * TP_W'(G2S);
    end
  end

  assign t = $signed(f4_tp[TP_W-1:8]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f5_cmd <= f4_cmd;
      f5_idx <= f4_idx;
      f5_val <= f4_val;
      f5_ii <= f4_ii;
      f5_pa <= pa;
      f5_pb <= pb;
      f5_x0 <= (X0_W'(f4_dx) <<< UP) + X0_W'(t);
      f5_y0 <= (X0_W'(f4_dy) <<< UP) + X0_W'(t);
    end
  end

  assign gt = f5_x0 > f5_y0;

  always_comb begin
    ofs_x[0] = XW'(f5_x0);
    ofs_y[0] = XW'(f5_y0);
    ofs_x[1] = XW'(f5_x0) - (gt ? ONE_X : '0) + G2_X;
    ofs_y[1] = XW'(f5_y0) - (gt ? '0 : ONE_X) + G2_X;
    ofs_x[2] = XW'(f5_x0) - ONE_X + G2_X + G2_X;
    ofs_y[2] = XW'(f5_y0) - ONE_X + G2_X + G2_X;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      item.cmd <= f5_cmd;
      item.idx <= f5_idx;
      item.val <= f5_val;
      item.addr[0] <= f5_ii + f5_pa;
      item.addr[1] <= f5_ii + (gt ? AW'(1) : AW'(0)) + (gt ? f5_pa : f5_pb);
      item.addr[2] <= f5_ii + AW'(1) + f5_pb;
      for (int k = 0; k < 3; k++) begin
        item.ox[k] <= ofs_x[k][OW-1:0];
        item.oy[k] <= ofs_y[k][OW-1:0];
        item.far[k] <= !((&ofs_x[k][XW-1:OW-1]) || !(|ofs_x[k][XW-1:OW-1])) ||
                       !((&ofs_y[k][XW-1:OW-1]) || !(|ofs_y[k][XW-1:OW-1]));
      end
    end
  end

endmodule

[design/sn2d_corner.sv]
module sn2d_corner (
  input  logic                                  clk,
  input  logic [4:0]                            en,
  input  logic signed [sn2d_pkg::OFS_W-1:0]     x,
  input  logic signed [sn2d_pkg::OFS_W-1:0]     y,
  input  logic                                  far,
  input  logic [sn2d_pkg::GRAD_W-1:0]           g,
  output logic signed [sn2d_pkg::TERM_W-1:0]    term
);

  localparam int SQ_W = 50;
  localparam int DW = sn2d_pkg::DOT_W;
  localparam int TW = sn2d_pkg::TERM_W;
  localparam logic signed [SQ_W-1:0] HALF = SQ_W'(1) <<< 47;

  logic signed [SQ_W-1:0] c1_xx, c1_yy;
  logic                   c1_far;
  logic signed [DW-1:0]   c1_dot, c2_dot, c3_dot, c4_dot;
  logic signed [DW-1:0]   dot;
  logic signed [DW-1:0]   gx_x, gy_y;
  logic signed [SQ_W-1:0] r;
  logic [23:0]            c2_r;
  logic [47:0]            c3_r2p, c4_r4p;

  always_comb begin
    gx_x = g[0] ? -DW'(x) : DW'(x);
    if (g[2]) begin
      gy_y = '0;
    end else begin
      gy_y = g[1] ? -DW'(y) : DW'(y);
    end
    dot = gx_x + gy_y;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1_xx <= SQ_W'(x) * SQ_W'(x);
      c1_yy <= SQ_W'(y) * SQ_W'(y);
      c1_far <= far;
      c1_dot <= dot;
    end
  end

  assign r = HALF - c1_xx - c1_yy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c2_r <= (c1_far || r[SQ_W-1]) ? '0 : r[47:24];
      c2_dot <= c1_dot;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c3_r2p <= 48'(c2_r) * 48'(c2_r);
      c3_dot <= c2_dot;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c4_r4p <= 48'(c3_r2p[47:24]) * 48'(c3_r2p[47:24]);
      c4_dot <= c3_dot;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      term <= TW'($signed({1'b0, c4_r4p[44:24]})) * TW'(c4_dot);
    end
  end

endmodule

[design/sn2d_back.sv]
module sn2d_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  sn2d_pkg::hash_item_t                  item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sn2d_pkg::NOISE_W-1:0]   noise_value
);

  localparam int OW = sn2d_pkg::OFS_W;
  localparam int SUM_W = sn2d_pkg::SUM_W;
  localparam int SC_W = SUM_W + 7;
  localparam int RES_W = SC_W - 33;
  localparam int NW = sn2d_pkg::NOISE_W;
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(2 ** (NW - 1) - 1);
  localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(2 ** (NW - 1));

  logic [7:0] v;
  logic [7:0] en;
  logic       accept;
  logic       load;

  logic [sn2d_pkg::TABLE_DW-1:0]         g_raw [3];
  logic [OW-1:0]                          b0_ox [3];
  logic [OW-1:0]                          b0_oy [3];
  logic [2:0]                             b0_far;
  logic signed [sn2d_pkg::TERM_W-1:0]     term [3];
  logic signed [SUM_W-1:0]                b6_sum;
  logic signed [SC_W-1:0]                 scaled;
  logic signed [RES_W-1:0]                res;

  always_comb begin
    en[7] = !v[7] || out_ready;
    for (int k = 6; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign accept = in_valid && en[0];
  assign load = accept && (item.cmd == sn2d_pkg::CMD_LOAD);
  assign out_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid && (item.cmd == sn2d_pkg::CMD_EVAL);
      for (int k = 1; k <= 7; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        b0_ox[k] <= item.ox[k];
        b0_oy[k] <= item.oy[k];
      end
      b0_far <= item.far;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_corner
    sn2d_perm_ram u_ram (
      .clk     (clk),
      .wr_en   (load),
      .wr_addr (item.idx),
      .wr_data (item.val),
      .rd_en   (accept),
      .rd_addr (item.addr[k]),
      .rd_data (g_raw[k])
    );

    sn2d_corner u_corner (
      .clk  (clk),
      .en   (en[5:1]),
      .x    ($signed(b0_ox[k])),
      .y    ($signed(b0_oy[k])),
      .far  (b0_far[k]),
      .g    (g_raw[k][sn2d_pkg::GRAD_W-1:0]),
      .term (term[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      b6_sum <= SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
    end
  end

  assign scaled = (SC_W'(b6_sum) <<< 6) + (SC_W'(b6_sum) <<< 2) + (SC_W'(b6_sum) <<< 1);
  assign res = $signed(scaled[SC_W-1:33]);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      if (res > RES_MAX) begin
        noise_value <= RES_MAX[NW-1:0];
      end else if (res < RES_MIN) begin
        noise_value <= RES_MIN[NW-1:0];
      end else begin
        noise_value <= res[NW-1:0];
      end
    end
  end

endmodule

[design/simplex_noise_2d_unit.sv]
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | cmd, x_coord, y_coord, table_index, table_value
// output   | out_valid / out_ready | noise_value
//
// One item enters per cycle while the output is not stalled; an evaluate item's result
// passes through the fourteen-stage pipeline (six skew and hash stages, eight falloff and
// scaling stages). A load item writes the table on its way down
// and gives no result; evaluate items accepted after it see the new entry.
// Reset clears the valid bits only; table contents stay undefined until written.
// A stall holds each full stage while empty stages ahead keep filling.
module simplex_noise_2d_unit #(
  parameter int COORD_FRAC_BITS = sn2d_pkg::COORD_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic signed [sn2d_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [sn2d_pkg::COORD_W-1:0]   y_coord,
  input  logic [sn2d_pkg::TABLE_AW-1:0]         table_index,
  input  logic [sn2d_pkg::TABLE_DW-1:0]         table_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sn2d_pkg::NOISE_W-1:0]   noise_value
);

  logic                 mid_valid;
  logic                 mid_ready;
  sn2d_pkg::hash_item_t mid_item;

  sn2d_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .table_index (table_index),
    .table_value (table_value),
    .out_valid   (mid_valid),
    .out_ready   (mid_ready),
    .item        (mid_item)
  );

  sn2d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .item        (mid_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
  );

endmodule

[design/sn2d_checker.sv]
module sn2d_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [sn2d_pkg::NOISE_W-1:0]  noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("Result changed or dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result shown right after reset.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input held off while the output stage is empty.");

endmodule

bind simplex_noise_2d_unit sn2d_checker u_sn2d_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .noise_value (noise_value)
);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY = 14;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 130;

  localparam longint F2_SKEW = 64'sd393016785;
  localparam longint G2_UNSKEW = 64'sd907633386;
  localparam longint G2_OFS = 64'sd3545443;
  localparam longint ONE_OFS = 64'sd16777216;
  localparam longint HALF_R = 64'sd140737488355328;

  typedef struct {
    sn2d_pkg::cmd_t op;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  idx;
    logic [7:0]  val;
    bit          fixed;
    logic [15:0] noise;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic cmd;
  logic signed [sn2d_pkg::COORD_W-1:0] x_coord;
  logic signed [sn2d_pkg::COORD_W-1:0] y_coord;
  logic [sn2d_pkg::TABLE_AW-1:0] table_index;
  logic [sn2d_pkg::TABLE_DW-1:0] table_value;
  logic out_valid;
  logic out_ready;
  logic signed [sn2d_pkg::NOISE_W-1:0] noise_value;

  logic        drv_fixed;
  logic [15:0] drv_noise;

  logic [7:0] perm_model [sn2d_pkg::TABLE_DEPTH];
  logic [15:0] noise_queue [$];
  stim_row_t directed_rows [$];
  int errors;
  int accepted;
  int idle_cycles;
  int cycle_count;
  int hold_left;
  bit held;

  simplex_noise_2d_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .table_index(table_index),
    .table_value(table_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .noise_value(noise_value)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint corner_term(longint ox, longint oy, logic [2:0] g);
    longint r;
    longint r2;
    longint r4;
    longint dot;
    r = HALF_R - ox * ox - oy * oy;
    if (r < 0) begin
      return 0;
    end
    r = r >>> 24;
    r2 = (r * r) >>> 24;
    r4 = (r2 * r2) >>> 24;
    dot = (g[0] ? -ox : ox) + (g[2] ? 64'sd0 : (g[1] ? -oy : oy));
    return r4 * dot;
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] xin, logic [31:0] yin);
    longint xs;
    longint ys;
    longint s;
    longint i;
    longint j;
    longint t;
    longint x0;
    longint y0;
    longint sum;
    longint res;
    logic [7:0] ii;
    logic [7:0] jj;
    logic [7:0] i1;
    logic [7:0] j1;
    logic [2:0] g0;
    logic [2:0] g1;
    logic [2:0] g2;
    xs = longint'($signed(xin));
    ys = longint'($signed(yin));
    s = ((xs + ys) * F2_SKEW) >>> 30;
    i = (xs + s) >>> sn2d_pkg::COORD_FRAC_BITS;
    j = (ys + s) >>> sn2d_pkg::COORD_FRAC_BITS;
    t = ((i + j) * G2_UNSKEW) >>> 8;
    x0 = (xs - (i <<< sn2d_pkg::COORD_FRAC_BITS))
       * (64'sd1 <<< (24 - sn2d_pkg::COORD_FRAC_BITS)) + t;
    y0 = (ys - (j <<< sn2d_pkg::COORD_FRAC_BITS))
       * (64'sd1 <<< (24 - sn2d_pkg::COORD_FRAC_BITS)) + t;
    i1 = (x0 > y0) ? 8'd1 : 8'd0;
    j1 = (x0 > y0) ? 8'd0 : 8'd1;
    ii = i[7:0];
    jj = j[7:0];
    g0 = perm_model[8'(ii + perm_model[jj])][2:0];
    g1 = perm_model[8'(ii + i1 + perm_model[8'(jj + j1)])][2:0];
    g2 = perm_model[8'(ii + 8'd1 + perm_model[8'(jj + 8'd1)])][2:0];
    sum = corner_term(x0, y0, g0)
        + corner_term(x0 - longint'(i1) * ONE_OFS + G2_OFS,
                      y0 - longint'(j1) * ONE_OFS + G2_OFS, g1)
        + corner_term(x0 - ONE_OFS + 2 * G2_OFS, y0 - ONE_OFS + 2 * G2_OFS, g2);
    res = (sum * 70) >>> 33;
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    return res[15:0];
  endfunction

  // Prediction at input acceptance, comparison at output acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        accepted++;
        if (cmd == sn2d_pkg::CMD_LOAD) begin
          perm_model[table_index] = table_value;
        end else begin
          noise_queue.push_back(drv_fixed ? drv_noise : noise_at(x_coord, y_coord));
        end
      end
      if (out_valid && out_ready) begin
        if (noise_queue.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value);
          errors++;
        end else begin
          if (noise_value !== noise_queue[0]) begin
            $error("noise_value: expected %0d, actual %0d",
                   $signed(noise_queue[0]), noise_value);
            errors++;
          end
          void'(noise_queue.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver: alternating stretches of random stalls and full throughput,
  // plus one long hold-off so the pipeline fills and backs up the input.
  initial begin
    out_ready = 1'b0;
    cycle_count = 0;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && accepted >= 300) begin
        held = 1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if ((cycle_count / 400) % 3 == 1) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  int burst_left;

  task automatic send_item(stim_row_t row);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= row.op;
    x_coord <= row.x;
    y_coord <= row.y;
    table_index <= row.idx;
    table_value <= row.val;
    drv_fixed <= row.fixed;
    drv_noise <= row.noise;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic stim_row_t make_row(sn2d_pkg::cmd_t op, logic [31:0] x, logic [31:0] y,
                                         logic [7:0] idx, logic [7:0] val,
                                         bit fixed, logic [15:0] noise);
    stim_row_t row;
    row.op = op;
    row.x = x;
    row.y = y;
    row.idx = idx;
    row.val = val;
    row.fixed = fixed;
    row.noise = noise;
    return row;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
      2: return {16'($urandom_range(0, 15) - 32'd8), 16'h0000}
                + 32'($urandom_range(0, 3)) - 32'd1;
      default: return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    endcase
  endfunction

  initial begin
    logic [7:0] shuffle [sn2d_pkg::TABLE_DEPTH];
    logic [7:0] tmp;
    int k;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = sn2d_pkg::CMD_EVAL;
    x_coord = '0;
    y_coord = '0;
    table_index = '0;
    table_value = '0;
    drv_fixed = 1'b0;
    drv_noise = '0;
    errors = 0;
    accepted = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table with a shuffled permutation before any evaluation.
    for (k = 0; k < sn2d_pkg::TABLE_DEPTH; k++) begin
      shuffle[k] = k[7:0];
    end
    for (k = sn2d_pkg::TABLE_DEPTH - 1; k > 0; k--) begin
      n = $urandom_range(0, k);
      tmp = shuffle[k];
      shuffle[k] = shuffle[n];
      shuffle[n] = tmp;
    end
    for (k = 0; k < sn2d_pkg::TABLE_DEPTH; k++) begin
      send_item(make_row(sn2d_pkg::CMD_LOAD, $urandom(), $urandom(), k[7:0], shuffle[k],
                         0, 0));
    end

    // The origin lies on a lattice corner with every other corner out of reach.
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 0, 0, 0, 0, 1, 16'sd0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h7fff_ffff, 32'h7fff_ffff,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h8000_0000, 32'h8000_0000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h7fff_ffff, 32'h8000_0000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h8000_0000, 32'h7fff_ffff,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'hffff_ffff, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 0, 32'hffff_ffff, 0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h0000_8000, 32'h0000_4000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h0000_4000, 32'h0000_8000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h0000_6000, 32'h0000_6000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h00ff_c000, 32'h00ff_a000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_LOAD, 0, 0, 8'd0, 8'd255, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_LOAD, 0, 0, 8'd255, 8'd0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h0000_3000, 32'h0000_1000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'hffff_d000, 32'hffff_e000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_LOAD, 0, 0, 8'd255, 8'd255, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_LOAD, 0, 0, 8'd0, 8'd0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'hffff_d000, 32'hffff_e000,
                                     0, 0, 0, 0));
    directed_rows.push_back(make_row(sn2d_pkg::CMD_EVAL, 32'h0001_0000, 32'h0001_0000,
                                     0, 0, 0, 0));
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r]);
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 6) == 0) begin
        send_item(make_row(sn2d_pkg::CMD_LOAD, $urandom(), $urandom(),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0));
      end else begin
        send_item(make_row(sn2d_pkg::CMD_EVAL, rand_coord(), rand_coord(),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0));
      end
    end
    in_valid <= 1'b0;

    while (noise_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 6) @(posedge clk);
    if (errors == 0 && noise_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
